@@ src/cnf_pkg.sv @@
// Shared types, sizes and codes for the color-name cell feature block.
// No dependencies; imported by cnf_divider and the top level.
package cnf_pkg;

  localparam int FEATURE_DIMS  = 10;
  localparam int TABLE_ENTRIES = 32768;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_BIN       = 16;

  localparam int VAL_W     = 16;   // Q2.14 feature word
  localparam int SUM_W     = 24;   // cell sum
  localparam int CH_W      = 8;    // color channel
  localparam int IDX_W     = 15;   // quantized color index
  localparam int DIM_W     = 4;
  localparam int POS_W     = 10;   // cell index fields of a result
  localparam int BIN_W     = 5;
  localparam int SIZE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int TBL_DEPTH = TABLE_ENTRIES * FEATURE_DIMS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int SUM_DEPTH = MAX_HEIGHT * FEATURE_DIMS;
  localparam int SUM_AW    = $clog2(SUM_DEPTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RIB_W     = $clog2(MAX_BIN);
  localparam int AREA_W    = $clog2(MAX_BIN * MAX_BIN + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;

  // reset values
  localparam logic [BIN_W-1:0]  BIN_RESET    = 5'd1;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd64;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd64;

  // item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [CH_W-1:0]         blue;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         red;
    logic [IDX_W-1:0]        table_address;
    logic [DIM_W-1:0]        table_dim;
    logic signed [VAL_W-1:0] table_value;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]        cell_row;
    logic [POS_W-1:0]        cell_col;
    logic [DIM_W-1:0]        dim;
    logic signed [VAL_W-1:0] feature;
    logic                    last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_DIV,
    S_OUT
  } state_t;

endpackage

@@ src/cnf_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/cnf_divider.sv @@
// Bit-serial restoring divider: signed cell sum over the unsigned cell area,
// truncated toward zero. One quotient bit per cycle. Uses cnf_pkg.
module cnf_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [cnf_pkg::SUM_W-1:0] dividend,
  input  logic [cnf_pkg::AREA_W-1:0]       divisor,
  output logic                             done,
  output logic signed [cnf_pkg::VAL_W-1:0] quotient
);
  import cnf_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  work;     // dividend bits out, quotient bits in
  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] dvsr;
  logic              neg;

  logic [AREA_W:0]   trial;
  logic              fits;
  logic [AREA_W-1:0] rem_next;
  logic [SUM_W-1:0]  work_next;

  always_comb begin
    trial     = {rem, work[SUM_W-1]};
    fits      = trial >= {1'b0, dvsr};
    rem_next  = fits ? AREA_W'(trial - {1'b0, dvsr}) : AREA_W'(trial);
    work_next = {work[SUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_W'(SUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= '0;
      rem   <= '0;
      dvsr  <= divisor;
      neg   <= dividend[SUM_W-1];
      work  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    end else if (busy) begin
      count <= count + 1'b1;
      rem   <= rem_next;
      work  <= work_next;
    end
  end

  // magnitude of the average is below 2^15 + 1, so the low bits carry it
  assign quotient = neg ? VAL_W'(-work) : VAL_W'(work);

endmodule

@@ src/color_name_cell_features.sv @@
// Color-name cell feature top level. Uses cnf_pkg, cnf_ram, cnf_divider.
// A table write or a pixel outside a complete cell leaves the sequencer
// idle; other pixels read and accumulate each dimension; a cell-closing
// pixel also divides and loads the output per dimension; output stall adds on.
// Reset (sync, rst high): registers to defaults, frame position to zero, no
// clearing pass; the feature table is undefined until written.
module color_name_cell_features (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [cnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnf_pkg::CFG_W-1:0]     cfg_data,
  // input transactions
  input  logic                          item_valid,
  output logic                          item_stall,
  input  cnf_pkg::item_t                item,
  // result transactions
  output logic                          result_valid,
  input  logic                          result_stall,
  output cnf_pkg::result_t              result
);
  import cnf_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers, stored raw and clamped on use
  // ---------------------------------------------------------------------
  logic [BIN_W-1:0]  bin_size;
  logic [SIZE_W-1:0] image_height;
  logic [SIZE_W-1:0] image_width;
  logic              cfg_hit;      // write to a known register restarts frame

  assign cfg_hit = cfg_write && (cfg_index == REG_BIN_SIZE ||
                                 cfg_index == REG_IMAGE_HEIGHT ||
                                 cfg_index == REG_IMAGE_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size     <= BIN_RESET;
      image_height <= HEIGHT_RESET;
      image_width  <= WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIN_SIZE:     bin_size     <= BIN_W'(cfg_data);
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        default:          ;
      endcase
    end
  end

  logic [BIN_W-1:0]  bin_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] w_eff;
  logic [RIB_W-1:0]  bin_last;      // position of the last pixel in a cell
  logic [AREA_W-1:0] area;

  always_comb begin
    if (bin_size == '0)                  bin_eff = BIN_W'(1);
    else if (bin_size > BIN_W'(MAX_BIN)) bin_eff = BIN_W'(MAX_BIN);
    else                                 bin_eff = bin_size;
    if (image_height == '0)                    h_eff = SIZE_W'(1);
    else if (image_height > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else                                       h_eff = image_height;
    if (image_width == '0)                   w_eff = SIZE_W'(1);
    else if (image_width > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    else                                     w_eff = image_width;
    bin_last = RIB_W'(bin_eff - 1'b1);
    area     = AREA_W'(bin_eff) * AREA_W'(bin_eff);
  end

  // ---------------------------------------------------------------------
  // Frame position. Besides the raw row/column, the cell index, the offset
  // inside the cell and the cell's first row/column are tracked, so no
  // division by bin size is needed.
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] row_count, crow, row_base;
  logic [COL_W-1:0] col_count, ccol, col_base;
  logic [RIB_W-1:0] rib, cib;

  logic pix_accept;
  logic tbl_accept;
  logic in_region;      // pixel lies in a complete cell
  logic row_wrap, col_wrap;

  assign pix_accept = item_valid && !item_stall && item.command == CMD_PIXEL;
  assign tbl_accept = item_valid && !item_stall && item.command == CMD_TABLE;

  assign in_region =
      (SIZE_W'(row_base) + SIZE_W'(bin_eff) <= h_eff) &&
      (SIZE_W'(col_base) + SIZE_W'(bin_eff) <= w_eff);
  assign row_wrap = SIZE_W'(row_count) + 1'b1 >= h_eff;
  assign col_wrap = SIZE_W'(col_count) + 1'b1 >= w_eff;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_count <= '0;
      crow      <= '0;
      row_base  <= '0;
      rib       <= '0;
      col_count <= '0;
      ccol      <= '0;
      col_base  <= '0;
      cib       <= '0;
    end else if (pix_accept) begin
      if (row_wrap) begin
        row_count <= '0;
        crow      <= '0;
        row_base  <= '0;
        rib       <= '0;
        if (col_wrap) begin
          col_count <= '0;
          ccol      <= '0;
          col_base  <= '0;
          cib       <= '0;
        end else begin
          col_count <= col_count + 1'b1;
          if (cib == bin_last) begin
            cib      <= '0;
            ccol     <= ccol + 1'b1;
            col_base <= col_base + COL_W'(bin_eff);
          end else begin
            cib <= cib + 1'b1;
          end
        end
      end else begin
        row_count <= row_count + 1'b1;
        if (rib == bin_last) begin
          rib      <= '0;
          crow     <= crow + 1'b1;
          row_base <= row_base + ROW_W'(bin_eff);
        end else begin
          rib <= rib + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Per-transaction context latched at accept
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  color_idx;
  logic [TBL_AW-1:0] idx_base;
  logic [SUM_AW-1:0] sum_base;
  logic [ROW_W-1:0]  pix_crow;
  logic [COL_W-1:0]  pix_ccol;
  logic              pix_first;    // top-left pixel: sums restart here
  logic              pix_emit;     // bottom-right pixel: cell completes
  logic [DIM_W-1:0]  dim_count;
  logic              dim_last;
  logic              dim_step;

  // red + green<<5 + blue<<10 on the 5-bit channels
  assign color_idx = {item.blue[CH_W-1:3], item.green[CH_W-1:3], item.red[CH_W-1:3]};
  assign dim_last  = dim_count == DIM_W'(FEATURE_DIMS - 1);

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      idx_base  <= TBL_AW'(color_idx) * TBL_AW'(FEATURE_DIMS);
      sum_base  <= SUM_AW'(crow) * SUM_AW'(FEATURE_DIMS);
      pix_crow  <= crow;
      pix_ccol  <= ccol;
      pix_first <= rib == '0 && cib == '0;
      pix_emit  <= rib == bin_last && cib == bin_last;
      dim_count <= '0;
    end else if (dim_step) begin
      dim_count <= dim_count + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Memories: feature table and per-cell-row running sums of the current
  // strip of cell columns. Sums never need clearing: a cell's top-left
  // pixel overwrites instead of adding.
  // ---------------------------------------------------------------------
  logic                    tbl_we;
  logic [TBL_AW-1:0]       tbl_waddr;
  logic [TBL_AW-1:0]       tbl_raddr;
  logic [VAL_W-1:0]        tbl_rdata;
  logic                    sum_we;
  logic [SUM_AW-1:0]       sum_addr;
  logic [SUM_W-1:0]        sum_rdata;
  logic signed [SUM_W-1:0] acc_value;

  assign tbl_we    = tbl_accept &&
                     ({1'b0, item.table_dim} < (DIM_W + 1)'(FEATURE_DIMS));
  assign tbl_waddr = TBL_AW'(item.table_address) * TBL_AW'(FEATURE_DIMS)
                   + TBL_AW'(item.table_dim);
  assign tbl_raddr = idx_base + TBL_AW'(dim_count);
  assign sum_addr  = sum_base + SUM_AW'(dim_count);

  assign acc_value = pix_first
                   ? SUM_W'($signed(tbl_rdata))
                   : $signed(sum_rdata) + SUM_W'($signed(tbl_rdata));

  cnf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (item.table_value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  cnf_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SUM_DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_addr),
    .wdata (acc_value),
    .raddr (sum_addr),
    .rdata (sum_rdata)
  );

  // ---------------------------------------------------------------------
  // Shared divider for the cell average
  // ---------------------------------------------------------------------
  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_quotient;

  cnf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_value),
    .divisor  (area),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // ---------------------------------------------------------------------
  // Sequencer: per dimension READ -> ACC, and on a closing pixel
  // DIV -> OUT before the next dimension.
  // ---------------------------------------------------------------------
  state_t  state, state_next;
  logic    result_load;
  result_t result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    sum_we      = 1'b0;
    div_start   = 1'b0;
    result_load = 1'b0;
    dim_step    = 1'b0;
    case (state)
      S_IDLE: begin
        if (pix_accept && in_region) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        sum_we = 1'b1;
        if (pix_emit) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (dim_last) begin
          state_next = S_IDLE;
        end else begin
          dim_step   = 1'b1;
          state_next = S_READ;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          if (dim_last) begin
            state_next = S_IDLE;
          end else begin
            dim_step   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign item_stall = state != S_IDLE;

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_comb begin
    result_next.cell_row = POS_W'(pix_crow);
    result_next.cell_col = POS_W'(pix_ccol);
    result_next.dim      = dim_count;
    result_next.feature  = div_quotient;
    result_next.last     = dim_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    result_load && result_next.last |=> state == S_IDLE && result_valid)
    else $error("last result of a cell did not return to idle");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> row_count == '0 && col_count == '0 && rib == '0 && cib == '0)
    else $error("register write did not restart the frame");

endmodule
